// File: sv/agc_pkg.sv
// ----------------------------------------------------------------------------
// agc_pkg
// Shared types, constants and helpers for the adjacency matrix graph checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package agc_pkg;

  localparam int NumVert = 16;
  localparam int VertW   = $clog2(NumVert);
  localparam int CntW    = $clog2(NumVert + 1);
  localparam int ReqW    = 2;

  typedef enum logic [ReqW-1:0] {
    REQ_QUERY  = 2'd0,
    REQ_INSERT = 2'd1,
    REQ_REMOVE = 2'd2
  } req_e;

  typedef logic [NumVert-1:0] row_t;
  typedef row_t [NumVert-1:0] mat_t;

  typedef struct packed {
    logic [ReqW-1:0]  req_type;
    logic [VertW-1:0] vertex_a;
    logic [VertW-1:0] vertex_b;
  } req_t;

  typedef struct packed {
    logic             edge_present;
    logic [NumVert-1:0] neighbor_mask;
    logic [CntW-1:0]  neighbor_count;
    logic             is_complete;
    logic             is_regular;
    logic             bad_vertex;
  } res_t;

  typedef struct packed {
    logic             bad;
    logic [CntW-1:0]  used;
    row_t             used_mask;
  } ctl_t;

  // 16-bit population count as a two-level adder tree
  function automatic logic [CntW-1:0] popcnt(input row_t x);
    logic [2:0]      nib [4];
    logic [CntW-1:0] sum;
    for (int k = 0; k < 4; k++) begin
      nib[k] = 3'(x[4*k]) + 3'(x[4*k+1]) + 3'(x[4*k+2]) + 3'(x[4*k+3]);
    end
    sum = CntW'(nib[0]) + CntW'(nib[1]) + CntW'(nib[2]) + CntW'(nib[3]);
    return sum;
  endfunction

endpackage

`default_nettype wire

// File: sv/agc_matrix.sv
// ----------------------------------------------------------------------------
// agc_matrix
// Adjacency matrix store: range check, mirrored insert/remove, row registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module agc_matrix (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              apply_i,
  input  wire logic [4:0]        vcount_i,
  input  wire agc_pkg::req_t     req_i,
  output agc_pkg::mat_t          rows_o,
  output agc_pkg::ctl_t          ctl_o
);

  agc_pkg::mat_t              rows_q, rows_d;
  logic [agc_pkg::CntW-1:0]   used;
  agc_pkg::row_t              umask;
  logic                       bad;

  always_comb begin
    used = (vcount_i > agc_pkg::CntW'(agc_pkg::NumVert)) ?
           agc_pkg::CntW'(agc_pkg::NumVert) : vcount_i;
    for (int j = 0; j < agc_pkg::NumVert; j++) begin
      umask[j] = agc_pkg::CntW'(j) < used;
    end
    bad = ({1'b0, req_i.vertex_a} >= used) || ({1'b0, req_i.vertex_b} >= used);
  end

  always_comb begin
    rows_d = rows_q;
    for (int i = 0; i < agc_pkg::NumVert; i++) begin
      if (!bad) begin
        case (agc_pkg::req_e'(req_i.req_type))
          agc_pkg::REQ_INSERT: begin
            if (req_i.vertex_a == agc_pkg::VertW'(i)) rows_d[i][req_i.vertex_b] = 1'b1;
            if (req_i.vertex_b == agc_pkg::VertW'(i)) rows_d[i][req_i.vertex_a] = 1'b1;
          end
          agc_pkg::REQ_REMOVE: begin
            if (req_i.vertex_a == agc_pkg::VertW'(i)) rows_d[i][req_i.vertex_b] = 1'b0;
            if (req_i.vertex_b == agc_pkg::VertW'(i)) rows_d[i][req_i.vertex_a] = 1'b0;
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= '0;
    end else if (apply_i) begin
      rows_q <= rows_d;
    end
  end

  assign rows_o          = rows_d;
  assign ctl_o.bad       = bad;
  assign ctl_o.used      = used;
  assign ctl_o.used_mask = umask;

endmodule

`default_nettype wire

// File: sv/agc_stats.sv
// ----------------------------------------------------------------------------
// agc_stats
// Degree counts, completeness and regularity flags, and the result beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module agc_stats (
  input  wire agc_pkg::mat_t     rows_i,
  input  wire agc_pkg::ctl_t     ctl_i,
  input  wire agc_pkg::req_t     req_i,
  output agc_pkg::res_t          res_o
);

  logic [agc_pkg::CntW-1:0] deg [agc_pkg::NumVert];
  logic                     complete;
  logic                     regular;
  agc_pkg::row_t            row_a;

  always_comb begin
    complete = 1'b1;
    regular  = 1'b1;
    for (int i = 0; i < agc_pkg::NumVert; i++) begin
      deg[i] = agc_pkg::popcnt(rows_i[i] & ctl_i.used_mask);
    end
    for (int i = 0; i < agc_pkg::NumVert; i++) begin
      if (agc_pkg::CntW'(i) < ctl_i.used) begin
        if (({1'b0, deg[i]} + (agc_pkg::CntW+1)'(1)) < {1'b0, ctl_i.used}) complete = 1'b0;
        if (deg[i] != deg[0]) regular = 1'b0;
      end
    end
  end

  assign row_a = rows_i[req_i.vertex_a];

  always_comb begin
    res_o.edge_present   = !ctl_i.bad && row_a[req_i.vertex_b];
    res_o.neighbor_mask  = ctl_i.bad ? '0 : (row_a & ctl_i.used_mask);
    res_o.neighbor_count = ctl_i.bad ? '0 : deg[req_i.vertex_a];
    res_o.is_complete    = complete;
    res_o.is_regular     = regular;
    res_o.bad_vertex     = ctl_i.bad;
  end

endmodule

`default_nettype wire

// File: sv/adjacency_matrix_graph_checker.sv
// ----------------------------------------------------------------------------
// adjacency_matrix_graph_checker
// Undirected graph of up to 16 vertices held as a symmetric bit matrix.
// ----------------------------------------------------------------------------
// Usage:
//   Request beats (req_type, vertex_a, vertex_b) enter on in_valid_i while
//   in_stall_o is low. Each request yields exactly one result beat on
//   out_valid_o, held until out_stall_i is low at a clock edge.
//   The beat is captured into an input register; the matrix row update,
//   sixteen row popcounts and flags then load into the output register.
//   Throughput is one request per cycle while the output is not stalled,
//   with a read-modify-write of the flop-based matrix for each request.
//   A stalled output register holds its beat; the input register then
//   fills and in_stall_o rises until the receiver takes the result.
//   Reset clears the matrix (no edges) and sets vertex_count to 16.
//   vertex_count is written through cfg_we_i / cfg_wdata_i; the user must
//   do so only while idle, as the block itself does not enforce it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module adjacency_matrix_graph_checker (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [4:0]        cfg_wdata_i,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire agc_pkg::req_t     in_data_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output agc_pkg::res_t          out_data_o
);

  logic [4:0]     vcount_q;
  logic           in_vld_q, in_vld_d;
  agc_pkg::req_t  in_q;
  logic           out_vld_q, out_vld_d;
  agc_pkg::res_t  out_q;
  logic           out_free, fire, in_acc;
  agc_pkg::mat_t  rows;
  agc_pkg::ctl_t  ctl;
  agc_pkg::res_t  res;

  assign out_free   = !out_vld_q || !out_stall_i;
  assign fire       = in_vld_q && out_free;
  assign in_stall_o = in_vld_q && !out_free;
  assign in_acc     = in_valid_i && !in_stall_o;

  always_comb begin
    in_vld_d = in_vld_q;
    if (in_acc) begin
      in_vld_d = 1'b1;
    end else if (fire) begin
      in_vld_d = 1'b0;
    end
    out_vld_d = out_vld_q;
    if (fire) begin
      out_vld_d = 1'b1;
    end else if (out_free) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcount_q  <= 5'd16;
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (cfg_we_i) vcount_q <= cfg_wdata_i;
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) in_q  <= in_data_i;
    if (fire)   out_q <= res;
  end

  agc_matrix u_matrix (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .apply_i  (fire),
    .vcount_i (vcount_q),
    .req_i    (in_q),
    .rows_o   (rows),
    .ctl_o    (ctl)
  );

  agc_stats u_stats (
    .rows_i (rows),
    .ctl_i  (ctl),
    .req_i  (in_q),
    .res_o  (res)
  );

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire
